// ===== rtl/core/sct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants of the segment crossing test pipeline.
// ----------------------------------------------------------------------------
package sct_pkg;

	localparam int COORD_WIDTH_DEF = 16;

	// coordinate bundle layout: first line p, second line q
	localparam int NUM_CRD = 8;
	localparam int CRD_PX0 = 0;
	localparam int CRD_PY0 = 1;
	localparam int CRD_PX1 = 2;
	localparam int CRD_PY1 = 3;
	localparam int CRD_QX0 = 4;
	localparam int CRD_QY0 = 5;
	localparam int CRD_QX1 = 6;
	localparam int CRD_QY1 = 7;

	// command codes
	localparam logic CMD_SEGMENT = 1'b0;
	localparam logic CMD_BOX     = 1'b1;

	// box side issued in a given cycle
	typedef enum logic [1:0] {
		SIDE_LOW,
		SIDE_RIGHT,
		SIDE_HIGH,
		SIDE_LEFT
	} box_side_t;

	typedef enum logic {
		ISS_IDLE,
		ISS_BOX
	} iss_state_t;

	// control that travels with each intersect operation
	typedef struct packed {
		logic vld;
		logic last;
		logic box;
	} op_ctrl_t;

endpackage

// ===== rtl/core/sct_issue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_issue
// Input sequencer: one operation per segment transaction, four per box
// transaction (one side per cycle while en is high) into the first stage.
// ----------------------------------------------------------------------------
module sct_issue #(
	parameter int W = sct_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  command,
	input  logic [sct_pkg::NUM_CRD-1:0][W-1:0]    in_crd,
	output sct_pkg::op_ctrl_t                     ctrl_s1,
	output logic [sct_pkg::NUM_CRD-1:0][W-1:0]    crd_s1
);
	import sct_pkg::*;

	iss_state_t state_q, state_nxt;
	box_side_t side_q, side_nxt, side_sel;
	logic [NUM_CRD-1:0][W-1:0] hold_q, src, op_crd;
	op_ctrl_t op_ctrl;
	logic accept, box_sel;

	assign accept = in_valid && in_ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		side_nxt  = side_q;
		case (state_q)
			ISS_IDLE: begin
				if (accept && command == CMD_BOX) begin
					state_nxt = ISS_BOX;
					side_nxt  = SIDE_RIGHT;
				end
			end
			ISS_BOX: begin
				if (en) begin
					case (side_q)
						SIDE_RIGHT: side_nxt = SIDE_HIGH;
						SIDE_HIGH:  side_nxt = SIDE_LEFT;
						default: begin
							state_nxt = ISS_IDLE;
							side_nxt  = SIDE_LOW;
						end
					endcase
				end
			end
			default: state_nxt = ISS_IDLE;
		endcase
	end

	// outputs and operation select
	always_comb begin
		in_ready = en && (state_q == ISS_IDLE);
		if (state_q == ISS_BOX) begin
			src      = hold_q;
			side_sel = side_q;
			box_sel  = 1'b1;
			op_ctrl  = '{vld: 1'b1, last: (side_q == SIDE_LEFT), box: 1'b1};
		end else begin
			src      = in_crd;
			side_sel = SIDE_LOW;
			box_sel  = (command == CMD_BOX);
			op_ctrl  = '{vld: accept, last: (command == CMD_SEGMENT),
				box: (command == CMD_BOX)};
		end
		op_crd = src;
		if (box_sel) begin
			case (side_sel)
				SIDE_LOW: begin
					op_crd[CRD_QX0] = src[CRD_QX0];
					op_crd[CRD_QY0] = src[CRD_QY0];
					op_crd[CRD_QX1] = src[CRD_QX1];
					op_crd[CRD_QY1] = src[CRD_QY0];
				end
				SIDE_RIGHT: begin
					op_crd[CRD_QX0] = src[CRD_QX1];
					op_crd[CRD_QY0] = src[CRD_QY0];
					op_crd[CRD_QX1] = src[CRD_QX1];
					op_crd[CRD_QY1] = src[CRD_QY1];
				end
				SIDE_HIGH: begin
					op_crd[CRD_QX0] = src[CRD_QX0];
					op_crd[CRD_QY0] = src[CRD_QY1];
					op_crd[CRD_QX1] = src[CRD_QX1];
					op_crd[CRD_QY1] = src[CRD_QY1];
				end
				default: begin
					op_crd[CRD_QX0] = src[CRD_QX0];
					op_crd[CRD_QY0] = src[CRD_QY0];
					op_crd[CRD_QX1] = src[CRD_QX0];
					op_crd[CRD_QY1] = src[CRD_QY1];
				end
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ISS_IDLE;
			side_q  <= SIDE_LOW;
			ctrl_s1 <= '0;
		end else begin
			state_q <= state_nxt;
			side_q  <= side_nxt;
			if (en)
				ctrl_s1 <= op_ctrl;
		end
	end

	// box transaction held for the remaining sides
	always_ff @(posedge clk) begin
		if (accept)
			hold_q <= in_crd;
		if (en)
			crd_s1 <= op_crd;
	end

endmodule

// ===== rtl/core/sct_line_solve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_line_solve
// Line coefficients, determinant and both crossing numerators, split into
// stages of one subtract or one multiply each; ends in sign and magnitude.
// ----------------------------------------------------------------------------
module sct_line_solve #(
	parameter int W  = sct_pkg::COORD_WIDTH_DEF,
	parameter int NW = 3 * W + 4,
	parameter int DW = 2 * W + 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  sct_pkg::op_ctrl_t                     ctrl_s1,
	input  logic [sct_pkg::NUM_CRD-1:0][W-1:0]    crd_s1,
	output sct_pkg::op_ctrl_t                     ctrl_s7,
	output logic [sct_pkg::NUM_CRD-1:0][W-1:0]    crd_s7,
	output logic                                  nneg_x_s7,
	output logic [NW-1:0]                         nmag_x_s7,
	output logic                                  nneg_y_s7,
	output logic [NW-1:0]                         nmag_y_s7,
	output logic                                  dneg_s7,
	output logic [DW-1:0]                         dmag_s7,
	output logic                                  dzero_s7
);
	import sct_pkg::*;

	localparam int AW  = W + 1;
	localparam int PW  = 2 * W + 1;
	localparam int QW  = 2 * AW;
	localparam int CFW = 2 * W + 2;
	localparam int CW  = (CFW > 64) ? 64 : CFW;
	localparam int DFW = 2 * W + 3;
	localparam int PNW = CW + AW;
	localparam int NFW = PNW + 1;

	op_ctrl_t ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5, ctrl_s6;
	logic [NUM_CRD-1:0][W-1:0] crd_s2, crd_s3, crd_s4, crd_s5, crd_s6;

	logic signed [AW-1:0] a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [AW-1:0] a1_s3, b1_s3, a2_s3, b2_s3;
	logic signed [AW-1:0] a1_s4, b1_s4, a2_s4, b2_s4;
	logic signed [PW-1:0] ax1_s3, by1_s3, ax2_s3, by2_s3;
	logic signed [QW-1:0] dp1_s3, dp2_s3;
	logic signed [CFW-1:0] c1_full, c2_full;
	logic signed [DFW-1:0] d_full;
	logic signed [CW-1:0] c1_s4, c2_s4;
	logic [DW-1:0] d_s4, d_s5, d_s6;
	logic signed [PNW-1:0] px1_s5, px2_s5, py1_s5, py2_s5;
	logic signed [NFW-1:0] nx_full, ny_full;
	logic [NW-1:0] nx_s6, ny_s6;

	// valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
			ctrl_s6 <= '0;
			ctrl_s7 <= '0;
		end else if (en) begin
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
			ctrl_s6 <= ctrl_s5;
			ctrl_s7 <= ctrl_s6;
		end
	end

	// wide sums, truncated where the width is capped
	always_comb begin
		c1_full = -CFW'(ax1_s3) - CFW'(by1_s3);
		c2_full = -CFW'(ax2_s3) - CFW'(by2_s3);
		d_full  = DFW'(dp1_s3) - DFW'(dp2_s3);
		nx_full = NFW'(px1_s5) - NFW'(px2_s5);
		ny_full = NFW'(py1_s5) - NFW'(py2_s5);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s2: direction terms
			crd_s2 <= crd_s1;
			a1_s2  <= AW'($signed(crd_s1[CRD_PY1])) - AW'($signed(crd_s1[CRD_PY0]));
			b1_s2  <= AW'($signed(crd_s1[CRD_PX0])) - AW'($signed(crd_s1[CRD_PX1]));
			a2_s2  <= AW'($signed(crd_s1[CRD_QY1])) - AW'($signed(crd_s1[CRD_QY0]));
			b2_s2  <= AW'($signed(crd_s1[CRD_QX0])) - AW'($signed(crd_s1[CRD_QX1]));
			// s3: first products
			crd_s3 <= crd_s2;
			a1_s3  <= a1_s2;
			b1_s3  <= b1_s2;
			a2_s3  <= a2_s2;
			b2_s3  <= b2_s2;
			ax1_s3 <= PW'(a1_s2) * PW'($signed(crd_s2[CRD_PX0]));
			by1_s3 <= PW'(b1_s2) * PW'($signed(crd_s2[CRD_PY0]));
			ax2_s3 <= PW'(a2_s2) * PW'($signed(crd_s2[CRD_QX0]));
			by2_s3 <= PW'(b2_s2) * PW'($signed(crd_s2[CRD_QY0]));
			dp1_s3 <= QW'(b1_s2) * QW'(a2_s2);
			dp2_s3 <= QW'(b2_s2) * QW'(a1_s2);
			// s4: offsets and determinant
			crd_s4 <= crd_s3;
			a1_s4  <= a1_s3;
			b1_s4  <= b1_s3;
			a2_s4  <= a2_s3;
			b2_s4  <= b2_s3;
			c1_s4  <= c1_full[CW-1:0];
			c2_s4  <= c2_full[CW-1:0];
			d_s4   <= d_full[DW-1:0];
			// s5: numerator products
			crd_s5 <= crd_s4;
			d_s5   <= d_s4;
			px1_s5 <= PNW'(c1_s4) * PNW'(b2_s4);
			px2_s5 <= PNW'(c2_s4) * PNW'(b1_s4);
			py1_s5 <= PNW'(a1_s4) * PNW'(c2_s4);
			py2_s5 <= PNW'(a2_s4) * PNW'(c1_s4);
			// s6: numerators
			crd_s6 <= crd_s5;
			d_s6   <= d_s5;
			nx_s6  <= nx_full[NW-1:0];
			ny_s6  <= ny_full[NW-1:0];
			// s7: sign and magnitude for the dividers
			crd_s7    <= crd_s6;
			nneg_x_s7 <= nx_s6[NW-1];
			nmag_x_s7 <= nx_s6[NW-1] ? ('0 - nx_s6) : nx_s6;
			nneg_y_s7 <= ny_s6[NW-1];
			nmag_y_s7 <= ny_s6[NW-1] ? ('0 - ny_s6) : ny_s6;
			dneg_s7   <= d_s6[DW-1];
			dmag_s7   <= d_s6[DW-1] ? ('0 - d_s6) : d_s6;
			dzero_s7  <= (d_s6 == '0);
		end
	end

endmodule

// ===== rtl/core/sct_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_divider
// Pipelined restoring divider for both crossing coordinates, one quotient
// bit per stage. Quotients of more than W bits are flagged as overflow.
// ----------------------------------------------------------------------------
module sct_divider #(
	parameter int W  = sct_pkg::COORD_WIDTH_DEF,
	parameter int NW = 3 * W + 4,
	parameter int DW = 2 * W + 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  sct_pkg::op_ctrl_t                     in_ctrl,
	input  logic [sct_pkg::NUM_CRD-1:0][W-1:0]    in_crd,
	input  logic                                  nneg_x,
	input  logic [NW-1:0]                         nmag_x,
	input  logic                                  nneg_y,
	input  logic [NW-1:0]                         nmag_y,
	input  logic                                  dneg,
	input  logic [DW-1:0]                         dmag,
	input  logic                                  dzero,
	output sct_pkg::op_ctrl_t                     out_ctrl,
	output logic [sct_pkg::NUM_CRD-1:0][W-1:0]    out_crd,
	output logic [W-1:0]                          qmag_x,
	output logic                                  ovf_x,
	output logic                                  qneg_x,
	output logic [W-1:0]                          qmag_y,
	output logic                                  ovf_y,
	output logic                                  qneg_y,
	output logic                                  out_dzero
);
	import sct_pkg::*;

	localparam int HW = NW - W;
	localparam int XW = (HW > DW) ? HW : DW;

	op_ctrl_t                  ctrl_s [W+1];
	logic [NUM_CRD-1:0][W-1:0] crd_s  [W+1];
	logic [DW-1:0]             dm_s   [W+1];
	logic [DW-1:0]             rx_s   [W+1];
	logic [DW-1:0]             ry_s   [W+1];
	logic [W-1:0]              lox_s  [W+1];
	logic [W-1:0]              loy_s  [W+1];
	logic [W-1:0]              qx_s   [W+1];
	logic [W-1:0]              qy_s   [W+1];
	logic                      ovx_s  [W+1];
	logic                      ovy_s  [W+1];
	logic                      sx_s   [W+1];
	logic                      sy_s   [W+1];
	logic                      dz_s   [W+1];

	logic [XW-1:0] hx_w, hy_w, dm_w;

	// overflow check: quotient has more than W bits
	always_comb begin
		hx_w = XW'(nmag_x[NW-1:W]);
		hy_w = XW'(nmag_y[NW-1:W]);
		dm_w = XW'(dmag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctrl_s[0] <= '0;
		else if (en)
			ctrl_s[0] <= in_ctrl;
	end

	// entry stage: initial remainder from the high numerator bits
	always_ff @(posedge clk) begin
		if (en) begin
			crd_s[0] <= in_crd;
			dm_s[0]  <= dmag;
			rx_s[0]  <= hx_w[DW-1:0];
			ry_s[0]  <= hy_w[DW-1:0];
			lox_s[0] <= nmag_x[W-1:0];
			loy_s[0] <= nmag_y[W-1:0];
			qx_s[0]  <= '0;
			qy_s[0]  <= '0;
			ovx_s[0] <= (hx_w >= dm_w);
			ovy_s[0] <= (hy_w >= dm_w);
			sx_s[0]  <= nneg_x ^ dneg;
			sy_s[0]  <= nneg_y ^ dneg;
			dz_s[0]  <= dzero;
		end
	end

	// one quotient bit per stage
	for (genvar i = 1; i <= W; i++) begin : g_step
		logic [DW:0] tx, ty, dx, dy;
		logic gex, gey;

		always_comb begin
			tx  = {rx_s[i-1], lox_s[i-1][W-1]};
			ty  = {ry_s[i-1], loy_s[i-1][W-1]};
			gex = (tx >= {1'b0, dm_s[i-1]});
			gey = (ty >= {1'b0, dm_s[i-1]});
			dx  = tx - {1'b0, dm_s[i-1]};
			dy  = ty - {1'b0, dm_s[i-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				ctrl_s[i] <= '0;
			else if (en)
				ctrl_s[i] <= ctrl_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				crd_s[i] <= crd_s[i-1];
				dm_s[i]  <= dm_s[i-1];
				rx_s[i]  <= gex ? dx[DW-1:0] : tx[DW-1:0];
				ry_s[i]  <= gey ? dy[DW-1:0] : ty[DW-1:0];
				lox_s[i] <= {lox_s[i-1][W-2:0], 1'b0};
				loy_s[i] <= {loy_s[i-1][W-2:0], 1'b0};
				qx_s[i]  <= {qx_s[i-1][W-2:0], gex};
				qy_s[i]  <= {qy_s[i-1][W-2:0], gey};
				ovx_s[i] <= ovx_s[i-1];
				ovy_s[i] <= ovy_s[i-1];
				sx_s[i]  <= sx_s[i-1];
				sy_s[i]  <= sy_s[i-1];
				dz_s[i]  <= dz_s[i-1];
			end
		end
	end

	assign out_ctrl  = ctrl_s[W];
	assign out_crd   = crd_s[W];
	assign qmag_x    = qx_s[W];
	assign ovf_x     = ovx_s[W];
	assign qneg_x    = sx_s[W];
	assign qmag_y    = qy_s[W];
	assign ovf_y     = ovy_s[W];
	assign qneg_y    = sy_s[W];
	assign out_dzero = dz_s[W];

endmodule

// ===== rtl/core/sct_resolve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_resolve
// Signed quotient, saturation, span tests, box side merge and the output
// register.
// ----------------------------------------------------------------------------
module sct_resolve #(
	parameter int W = sct_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  sct_pkg::op_ctrl_t                     in_ctrl,
	input  logic [sct_pkg::NUM_CRD-1:0][W-1:0]    in_crd,
	input  logic [W-1:0]                          qmag_x,
	input  logic                                  ovf_x,
	input  logic                                  qneg_x,
	input  logic [W-1:0]                          qmag_y,
	input  logic                                  ovf_y,
	input  logic                                  qneg_y,
	input  logic                                  dzero,
	output logic                                  out_valid,
	output logic                                  crossed,
	output logic                                  point_valid,
	output logic signed [W-1:0]                   cross_x,
	output logic signed [W-1:0]                   cross_y
);
	import sct_pkg::*;

	localparam int VW = W + 2;
	localparam logic signed [VW-1:0] VMAX = {3'b000, {(W-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {3'b111, {(W-1){1'b0}}};
	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	op_ctrl_t ctrl_sr;
	logic [NUM_CRD-1:0][W-1:0] crd_sr;
	logic signed [VW-1:0] vx, vy, vx_sr, vy_sr;
	logic [W-1:0] satx, saty, satx_sr, saty_sr;
	logic okx_sr, oky_sr, pv_sr;
	logic hit, acc_q, out_valid_q;

	function automatic logic [W-1:0] sat_val(input logic signed [VW-1:0] v,
		input logic ovf, input logic neg);
		logic [W-1:0] r;
		if (ovf)
			r = neg ? SMIN : SMAX;
		else if (v > VMAX)
			r = SMAX;
		else if (v < VMIN)
			r = SMIN;
		else
			r = v[W-1:0];
		return r;
	endfunction

	function automatic logic in_span(input logic signed [W-1:0] e0,
		input logic signed [W-1:0] e1, input logic signed [VW-1:0] v);
		logic signed [W-1:0] lo, hi;
		lo = (e0 < e1) ? e0 : e1;
		hi = (e0 < e1) ? e1 : e0;
		return (v >= VW'(lo)) && (v <= VW'(hi));
	endfunction

	// signed quotient and saturated coordinate
	always_comb begin
		vx   = qneg_x ? -$signed({2'b00, qmag_x}) : $signed({2'b00, qmag_x});
		vy   = qneg_y ? -$signed({2'b00, qmag_y}) : $signed({2'b00, qmag_y});
		satx = sat_val(vx, ovf_x, qneg_x);
		saty = sat_val(vy, ovf_y, qneg_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctrl_sr <= '0;
		else if (en)
			ctrl_sr <= in_ctrl;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crd_sr  <= in_crd;
			vx_sr   <= vx;
			vy_sr   <= vy;
			satx_sr <= satx;
			saty_sr <= saty;
			okx_sr  <= !ovf_x;
			oky_sr  <= !ovf_y;
			pv_sr   <= !dzero;
		end
	end

	// crossing must sit inside both segments' spans
	always_comb begin
		hit = pv_sr && okx_sr && oky_sr
			&& in_span(crd_sr[CRD_PX0], crd_sr[CRD_PX1], vx_sr)
			&& in_span(crd_sr[CRD_PY0], crd_sr[CRD_PY1], vy_sr)
			&& in_span(crd_sr[CRD_QX0], crd_sr[CRD_QX1], vx_sr)
			&& in_span(crd_sr[CRD_QY0], crd_sr[CRD_QY1], vy_sr);
	end

	// merge of box sides and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctrl_sr.vld && ctrl_sr.last;
			if (ctrl_sr.vld)
				acc_q <= ctrl_sr.last ? 1'b0 : (acc_q | hit);
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (en && ctrl_sr.vld && ctrl_sr.last) begin
			crossed     <= acc_q | hit;
			point_valid <= !ctrl_sr.box && pv_sr;
			cross_x     <= (!ctrl_sr.box && pv_sr) ? satx_sr : '0;
			cross_y     <= (!ctrl_sr.box && pv_sr) ? saty_sr : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/segment_cross_test_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_cross_test_unit
// Segment against segment or axis-aligned box crossing test, signed fixed
// point coordinates.
// ----------------------------------------------------------------------------
// A segment transaction (command 0) is taken every cycle while the output is
// not stalled; a box transaction (command 1) occupies the input until its four
// sides have gone, one per cycle while not stalled, through the single shared
// intersect pipeline. From acceptance to result, a segment transaction passes
// the issue register, the six solve stages, the divider entry and its one
// quotient bit per stage, and the two resolve registers; a box result comes
// after its last side. A stalled output freezes the whole pipeline without loss.
module segment_cross_test_unit #(
	parameter int COORD_WIDTH = sct_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic signed [COORD_WIDTH-1:0] ax0,
	input  logic signed [COORD_WIDTH-1:0] ay0,
	input  logic signed [COORD_WIDTH-1:0] ax1,
	input  logic signed [COORD_WIDTH-1:0] ay1,
	input  logic signed [COORD_WIDTH-1:0] bx0,
	input  logic signed [COORD_WIDTH-1:0] by0,
	input  logic signed [COORD_WIDTH-1:0] bx1,
	input  logic signed [COORD_WIDTH-1:0] by1,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          crossed,
	output logic                          point_valid,
	output logic signed [COORD_WIDTH-1:0] cross_x,
	output logic signed [COORD_WIDTH-1:0] cross_y
);
	import sct_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int NFW = 3 * W + 4;
	localparam int DFW = 2 * W + 3;
	localparam int NW  = (NFW > 64) ? 64 : NFW;
	localparam int DW  = (DFW > 64) ? 64 : DFW;

	logic en;
	logic [NUM_CRD-1:0][W-1:0] in_crd, crd_s1, crd_s7, crd_dv;
	op_ctrl_t ctrl_s1, ctrl_s7, ctrl_dv;
	logic nneg_x, nneg_y, dneg, dzero;
	logic [NW-1:0] nmag_x, nmag_y;
	logic [DW-1:0] dmag;
	logic [W-1:0] qmag_x, qmag_y;
	logic ovf_x, ovf_y, qneg_x, qneg_y, dz_dv;

	// global advance: output register free or being emptied
	assign en = !out_valid || out_ready;

	assign in_crd = {by1, bx1, by0, bx0, ay1, ax1, ay0, ax0};

	sct_issue #(.W(W)) u_issue (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command (command),
		.in_crd  (in_crd),
		.ctrl_s1 (ctrl_s1),
		.crd_s1  (crd_s1)
	);

	sct_line_solve #(.W(W), .NW(NW), .DW(DW)) u_solve (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctrl_s1  (ctrl_s1),
		.crd_s1   (crd_s1),
		.ctrl_s7  (ctrl_s7),
		.crd_s7   (crd_s7),
		.nneg_x_s7(nneg_x),
		.nmag_x_s7(nmag_x),
		.nneg_y_s7(nneg_y),
		.nmag_y_s7(nmag_y),
		.dneg_s7  (dneg),
		.dmag_s7  (dmag),
		.dzero_s7 (dzero)
	);

	sct_divider #(.W(W), .NW(NW), .DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_ctrl  (ctrl_s7),
		.in_crd   (crd_s7),
		.nneg_x   (nneg_x),
		.nmag_x   (nmag_x),
		.nneg_y   (nneg_y),
		.nmag_y   (nmag_y),
		.dneg     (dneg),
		.dmag     (dmag),
		.dzero    (dzero),
		.out_ctrl (ctrl_dv),
		.out_crd  (crd_dv),
		.qmag_x   (qmag_x),
		.ovf_x    (ovf_x),
		.qneg_x   (qneg_x),
		.qmag_y   (qmag_y),
		.ovf_y    (ovf_y),
		.qneg_y   (qneg_y),
		.out_dzero(dz_dv)
	);

	sct_resolve #(.W(W)) u_resolve (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_ctrl    (ctrl_dv),
		.in_crd     (crd_dv),
		.qmag_x     (qmag_x),
		.ovf_x      (ovf_x),
		.qneg_x     (qneg_x),
		.qmag_y     (qmag_y),
		.ovf_y      (ovf_y),
		.qneg_y     (qneg_y),
		.dzero      (dz_dv),
		.out_valid  (out_valid),
		.crossed    (crossed),
		.point_valid(point_valid),
		.cross_x    (cross_x),
		.cross_y    (cross_y)
	);

endmodule

// ===== rtl/core/sct_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks of the segment crossing test unit, bound to the top.
// ----------------------------------------------------------------------------
module sct_checker #(
	parameter int COORD_WIDTH = sct_pkg::COORD_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          crossed,
	input logic                          point_valid,
	input logic signed [COORD_WIDTH-1:0] cross_x,
	input logic signed [COORD_WIDTH-1:0] cross_y
);

	// a stalled result transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(crossed) && $stable(point_valid)
			&& $stable(cross_x) && $stable(cross_y))
		else $error("result payload changed while stalled");

	// no crossing point reported means zero coordinates
	a_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> cross_x == '0 && cross_y == '0)
		else $error("coordinates set without a crossing point");

	// a stalled output backs up to the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while the pipeline is stalled");

endmodule

bind segment_cross_test_unit sct_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sct_checker (.*);
